// ===== rtl/dfe_pkg.sv =====
package dfe_pkg;

    localparam int CHANNELS  = 4;
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CH_W      = 3;
    localparam int POWER_W   = 16;
    localparam int CMD_W     = 8;
    localparam int TICK_W    = 8;
    localparam int MINP_W    = 14;
    localparam int CODE_W    = 11;
    localparam int FRAME_W   = 16;
    localparam int BIT_IDX_W = 4;
    localparam int Q_FRAC    = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 14;

    // Throttle mapping constants
    localparam logic signed [POWER_W-1:0] MAX_Q     = 16'sd32440;
    localparam logic signed [POWER_W-1:0] NEG_MAX_Q = -16'sd32440;
    localparam logic [CMD_W-1:0]  CMD_MAX      = 8'd47;
    localparam logic [11:0]       THR_POS_BASE = 12'd48;
    localparam logic [11:0]       THR_NEG_BASE = 12'd1048;
    localparam logic [11:0]       THR_CODE_MAX = 12'd2048;
    localparam logic [9:0]        THR_SCALE    = 10'd1000;
    localparam logic [10:0]       FLOOR_SCALE  = 11'd2000;
    localparam logic [6:0]        REPORT_NUM   = 7'd100;
    localparam logic [6:0]        REPORT_DEN   = 7'd101;

    // Item kinds
    localparam logic KIND_POWER = 1'b0;
    localparam logic KIND_CMD   = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_POWER = 3'd4;

    typedef struct packed {
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [MINP_W-1:0] min_power;
    } t_cfg;

    typedef struct packed {
        logic [CH_W-1:0]           channel;
        logic [FRAME_W-1:0]        frame;
        logic signed [POWER_W-1:0] reported;
    } t_frame_item;

endpackage

// ===== rtl/dfe_if.sv =====
interface dfe_in_if
    import dfe_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [CH_W-1:0]           channel;
    logic signed [POWER_W-1:0] power;
    logic [CMD_W-1:0]          command_code;

    modport source (output valid, kind, channel, power, command_code, input ready);
    modport sink   (input valid, kind, channel, power, command_code, output ready);
endinterface

interface dfe_out_if
    import dfe_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CH_W-1:0]           out_channel;
    logic [FRAME_W-1:0]        frame;
    logic                      bit_value;
    logic [TICK_W-1:0]         high_ticks;
    logic [TICK_W-1:0]         low_ticks;
    logic                      last;
    logic signed [POWER_W-1:0] reported_power;

    modport source (output valid, out_channel, frame, bit_value, high_ticks, low_ticks,
                    last, reported_power, input ready);
    modport sink   (input valid, out_channel, frame, bit_value, high_ticks, low_ticks,
                    last, reported_power, output ready);
endinterface

interface dfe_cfg_if
    import dfe_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/dfe_power_unit.sv =====
module dfe_power_unit
    import dfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    dfe_in_if.sink      i_in,
    output logic        o_valid,
    output t_frame_item o_item,
    input  logic        i_ready
);

    logic en;
    logic keep;
    logic [CH_IDX_W-1:0] rd_idx;

    // per-channel stored power
    logic signed [POWER_W-1:0] r_mem [CHANNELS];
    logic [CHANNELS-1:0]       r_mem_valid;
    logic signed [POWER_W-1:0] r_rd_data;

    logic                      r_s1_valid;
    logic                      r_s1_kind;
    logic [CH_W-1:0]           r_s1_ch;
    logic signed [POWER_W-1:0] r_s1_power;
    logic [CMD_W-1:0]          r_s1_cmd;

    logic                      r_s2_valid;
    logic                      r_s2_kind;
    logic [CH_W-1:0]           r_s2_ch;
    logic signed [POWER_W-1:0] r_s2_stored;
    logic [CMD_W-1:0]          r_s2_cmd;

    logic signed [POWER_W-1:0] p_clamp;
    logic signed [POWER_W-1:0] p_neg;
    logic [Q_FRAC-1:0]         p_mag;
    logic signed [POWER_W-1:0] min_s;
    logic signed [POWER_W-1:0] n_power;
    logic signed [POWER_W-1:0] n_stored;
    logic                      wr_en;
    logic [CH_IDX_W-1:0]       wr_idx;

    logic [POWER_W-1:0]        s_mag;
    logic [24:0]               thr_prod;
    logic [24:0]               floor_prod;
    logic [11:0]               code_raw;
    logic [11:0]               floor_code;
    logic [11:0]               code_lim;
    logic [CODE_W-1:0]         code;
    logic                      tel;
    logic [FRAME_W-1:0]        word;
    logic [3:0]                csum;
    logic [22:0]               rep_lhs;
    logic [22:0]               rep_rhs;

    assign en         = !r_s2_valid || i_ready;
    assign i_in.ready = en;
    assign keep       = ({1'b0, i_in.channel} < 4'(CHANNELS))
                        && !(i_in.kind == KIND_CMD && i_in.command_code > CMD_MAX);
    assign rd_idx     = i_in.channel[CH_IDX_W-1:0];

    // stage 1: clamp and minimum raise, write back
    always_comb begin
        if (r_s1_power >= MAX_Q) begin
            p_clamp = MAX_Q;
        end else if (r_s1_power <= NEG_MAX_Q) begin
            p_clamp = NEG_MAX_Q;
        end else begin
            p_clamp = r_s1_power;
        end
        p_neg = -p_clamp;
        p_mag = (p_clamp < 0) ? p_neg[Q_FRAC-1:0] : p_clamp[Q_FRAC-1:0];
        min_s = signed'({2'b00, i_cfg.min_power});
        if ({1'b0, p_mag} < {2'b00, i_cfg.min_power}) begin
            n_power = (r_rd_data < 0) ? -min_s : min_s;
        end else begin
            n_power = p_clamp;
        end
        n_stored = (r_s1_kind == KIND_POWER) ? n_power : r_rd_data;
    end

    assign wr_en  = en && r_s1_valid && (r_s1_kind == KIND_POWER);
    assign wr_idx = r_s1_ch[CH_IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= n_power;
        end
        // registered read, write in flight forwarded, unwritten entry reads zero
        if (en) begin
            if (wr_en && wr_idx == rd_idx) begin
                r_rd_data <= n_power;
            end else if (r_mem_valid[rd_idx]) begin
                r_rd_data <= r_mem[rd_idx];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_valid <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_mem_valid[wr_idx] <= 1'b1;
            end
            if (en) begin
                r_s1_valid <= i_in.valid && keep;
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_kind   <= i_in.kind;
            r_s1_ch     <= i_in.channel;
            r_s1_power  <= i_in.power;
            r_s1_cmd    <= i_in.command_code;
            r_s2_kind   <= r_s1_kind;
            r_s2_ch     <= r_s1_ch;
            r_s2_stored <= n_stored;
            r_s2_cmd    <= r_s1_cmd;
        end
    end

    // stage 2: throttle code, frame and reported power
    always_comb begin
        s_mag      = (r_s2_stored < 0) ? POWER_W'(-r_s2_stored) : POWER_W'(r_s2_stored);
        thr_prod   = 25'(s_mag[Q_FRAC-1:0]) * 25'(THR_SCALE);
        floor_prod = 25'(i_cfg.min_power) * 25'(FLOOR_SCALE);
        floor_code = THR_POS_BASE + 12'(floor_prod[24:Q_FRAC]);
        if (r_s2_stored > 0) begin
            code_raw = THR_POS_BASE + 12'(thr_prod[24:Q_FRAC]);
        end else begin
            code_raw = THR_NEG_BASE + 12'(thr_prod[24:Q_FRAC]);
        end
        if (code_raw < floor_code) begin
            code_lim = floor_code;
        end else if (code_raw > THR_CODE_MAX) begin
            code_lim = THR_CODE_MAX;
        end else begin
            code_lim = code_raw;
        end
        if (r_s2_kind == KIND_CMD) begin
            code = CODE_W'(r_s2_cmd);
            tel  = (r_s2_cmd != '0);
        end else begin
            code = code_lim[CODE_W-1:0];
            tel  = 1'b0;
        end
        word    = {code, tel, 4'b0000};
        csum    = word[7:4] ^ word[11:8] ^ word[15:12];
        rep_lhs = 23'(s_mag) * 23'(REPORT_NUM);
        rep_rhs = 23'(i_cfg.min_power) * 23'(REPORT_DEN);
    end

    assign o_valid          = r_s2_valid;
    assign o_item.channel   = r_s2_ch;
    assign o_item.frame     = {word[15:4], csum};
    assign o_item.reported  = (rep_lhs <= rep_rhs) ? '0 : r_s2_stored;

endmodule

// ===== rtl/dfe_serializer.sv =====
module dfe_serializer
    import dfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    input  t_frame_item i_item,
    output logic        o_ready,
    dfe_out_if.source   o_out
);

    logic                 r_busy;
    logic [BIT_IDX_W-1:0] r_idx;
    t_frame_item          r_item;
    logic                 last;
    logic                 load;
    logic [BIT_IDX_W-1:0] bit_sel;
    logic                 bit_val;

    assign last    = (r_idx == BIT_IDX_W'(FRAME_W - 1));
    // next frame loads right behind the last symbol of the current one
    assign load    = !r_busy || (o_out.ready && last);
    assign o_ready = load;
    assign bit_sel = BIT_IDX_W'(FRAME_W - 1) - r_idx;
    assign bit_val = r_item.frame[bit_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= i_valid;
            r_idx  <= '0;
        end else if (o_out.ready) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_out.valid          = r_busy;
    assign o_out.out_channel    = r_item.channel;
    assign o_out.frame          = r_item.frame;
    assign o_out.bit_value      = bit_val;
    assign o_out.high_ticks     = bit_val ? i_cfg.one_high : i_cfg.zero_high;
    assign o_out.low_ticks      = bit_val ? i_cfg.one_low : i_cfg.zero_low;
    assign o_out.last           = last;
    assign o_out.reported_power = r_item.reported;

endmodule

// ===== rtl/dshot_frame_encoder.sv =====
// DShot frame encoder. Each accepted item is a power request or a special command for one
// motor channel and yields 16 bit symbols, MSB first, each with its high and low tick counts;
// items for a channel at or above CHANNELS, and commands above 47, are dropped silently.
// The per-channel power sits in a small synchronous RAM that is read on accept and written
// back from stage 1, with the write forwarded to a read of the same channel. An item passes
// the stage 1 and stage 2 registers before the serializer loads it. The serializer sends
// one symbol per cycle while the output is ready and loads the next frame right behind the
// last symbol; input stalls only while stage 2 waits. Configuration writes are always ready.
module dshot_frame_encoder
    import dfe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    dfe_in_if.sink    i_in,
    dfe_out_if.source o_out,
    dfe_cfg_if.sink   i_cfg
);

    t_cfg        r_cfg;
    logic        pu_valid;
    t_frame_item pu_item;
    logic        ser_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_high <= 8'd40;
            r_cfg.zero_low  <= 8'd66;
            r_cfg.one_high  <= 8'd80;
            r_cfg.one_low   <= 8'd26;
            r_cfg.min_power <= 14'd655;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_ZERO_HIGH: r_cfg.zero_high <= i_cfg.data[TICK_W-1:0];
                REG_ZERO_LOW:  r_cfg.zero_low  <= i_cfg.data[TICK_W-1:0];
                REG_ONE_HIGH:  r_cfg.one_high  <= i_cfg.data[TICK_W-1:0];
                REG_ONE_LOW:   r_cfg.one_low   <= i_cfg.data[TICK_W-1:0];
                REG_MIN_POWER: r_cfg.min_power <= i_cfg.data[MINP_W-1:0];
                default: ;
            endcase
        end
    end

    dfe_power_unit u_power (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_valid (pu_valid),
        .o_item  (pu_item),
        .i_ready (ser_ready)
    );

    dfe_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (pu_valid),
        .i_item  (pu_item),
        .o_ready (ser_ready),
        .o_out   (o_out)
    );

    // frame checksum always matches its upper nibbles
    a_csum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.frame[3:0] ==
            (o_out.frame[15:12] ^ o_out.frame[11:8] ^ o_out.frame[7:4]))
        else $error("frame checksum mismatch");

    // symbols of one frame follow without a gap and keep the frame
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last |=>
            o_out.valid && $stable(o_out.frame) && $stable(o_out.out_channel))
        else $error("frame burst broken");

    // high tick count follows the bit value
    a_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.high_ticks ==
            (o_out.bit_value ? r_cfg.one_high : r_cfg.zero_high))
        else $error("high ticks do not match bit value");

endmodule

// ===== bench/dshot_frame_encoder_tb.sv =====
`timescale 1ns / 1ps

module dshot_frame_encoder_tb;
    import dfe_pkg::*;

    typedef struct {
        logic [CH_W-1:0]           chan;
        logic [FRAME_W-1:0]        frame;
        logic                      bit_val;
        logic [TICK_W-1:0]         hi_ticks;
        logic [TICK_W-1:0]         lo_ticks;
        logic                      last;
        logic signed [POWER_W-1:0] reported;
    } t_symbol;

    logic i_clk;
    logic i_rst_n;

    dfe_in_if  in_if();
    dfe_out_if out_if();
    dfe_cfg_if cfg_if();

    dshot_frame_encoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Shadow copy of the block's registers and per-channel power
    logic [TICK_W-1:0]         zero_hi_ticks;
    logic [TICK_W-1:0]         zero_lo_ticks;
    logic [TICK_W-1:0]         one_hi_ticks;
    logic [TICK_W-1:0]         one_lo_ticks;
    logic [MINP_W-1:0]         min_power_q;
    logic signed [POWER_W-1:0] chan_power [CHANNELS];

    t_symbol pending_symbols[$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int symbols_checked;
    int items_sent;
    int cfg_writes;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Works out the 16 bit symbols that one accepted item produces
    function automatic void predict_frame(input logic kind, input logic [CH_W-1:0] ch,
                                          input logic signed [POWER_W-1:0] pwr,
                                          input logic [CMD_W-1:0] cmd);
        int      p;
        int      mag;
        int      minp;
        int      code;
        int      floor_code;
        int      s;
        int      smag;
        logic    tel;
        logic [FRAME_W-1:0] word;
        logic [FRAME_W-1:0] frame;
        t_symbol sym;
        minp = int'(min_power_q);
        if (ch >= CHANNELS) return;
        if (kind == KIND_CMD) begin
            if (cmd > CMD_MAX) return;
            code = int'(cmd);
            tel  = (cmd != '0);
        end else begin
            p = pwr;
            if (p > int'(MAX_Q)) p = int'(MAX_Q);
            if (p < int'(NEG_MAX_Q)) p = int'(NEG_MAX_Q);
            mag = (p < 0) ? -p : p;
            // too small: take the minimum, keeping the sign of the stored power
            if (mag < minp) p = (chan_power[ch] < 0) ? -minp : minp;
            chan_power[ch] = p[POWER_W-1:0];
            if (p > 0)
                code = int'(THR_POS_BASE) + ((int'(THR_SCALE) * p) >>> Q_FRAC);
            else
                code = int'(THR_NEG_BASE) + ((int'(THR_SCALE) * (-p)) >>> Q_FRAC);
            floor_code = int'(THR_POS_BASE) + ((int'(FLOOR_SCALE) * minp) >>> Q_FRAC);
            if (code < floor_code) code = floor_code;
            if (code > int'(THR_CODE_MAX)) code = int'(THR_CODE_MAX);
            tel = 1'b0;
        end
        word  = {code[CODE_W-1:0], tel, 4'h0};
        frame = {word[15:4], word[15:12] ^ word[11:8] ^ word[7:4]};
        s     = chan_power[ch];
        smag  = (s < 0) ? -s : s;
        sym.chan     = ch;
        sym.frame    = frame;
        sym.reported = (smag * 100 <= minp * 101) ? '0 : chan_power[ch];
        for (int i = 0; i < FRAME_W; i++) begin
            sym.bit_val  = frame[FRAME_W-1-i];
            sym.hi_ticks = sym.bit_val ? one_hi_ticks : zero_hi_ticks;
            sym.lo_ticks = sym.bit_val ? one_lo_ticks : zero_lo_ticks;
            sym.last     = (i == FRAME_W - 1);
            pending_symbols.push_back(sym);
        end
    endfunction

    // Output side: random stall, compare each accepted symbol
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_symbol want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            symbols_checked++;
            if (pending_symbols.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected symbol ch=%0d frame=%h", $realtime,
                             out_if.out_channel, out_if.frame);
            end else begin
                want = pending_symbols.pop_front();
                if (out_if.out_channel !== want.chan || out_if.frame !== want.frame ||
                    out_if.bit_value !== want.bit_val || out_if.high_ticks !== want.hi_ticks ||
                    out_if.low_ticks !== want.lo_ticks || out_if.last !== want.last ||
                    out_if.reported_power !== want.reported) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: symbol mismatch", $realtime);
                        $display("  exp ch=%0d frame=%h bit=%b hi=%0d lo=%0d last=%b rep=%0d",
                                 want.chan, want.frame, want.bit_val, want.hi_ticks,
                                 want.lo_ticks, want.last, want.reported);
                        $display("  got ch=%0d frame=%h bit=%b hi=%0d lo=%0d last=%b rep=%0d",
                                 out_if.out_channel, out_if.frame, out_if.bit_value,
                                 out_if.high_ticks, out_if.low_ticks, out_if.last,
                                 out_if.reported_power);
                    end
                end
            end
        end
    end

    // Called at a falling edge; leaves valid high so back-to-back items need no toggle
    task automatic send_item(input logic kind, input logic [CH_W-1:0] ch,
                             input logic signed [POWER_W-1:0] pwr,
                             input logic [CMD_W-1:0] cmd);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.kind         <= kind;
        in_if.channel      <= ch;
        in_if.power        <= pwr;
        in_if.command_code <= cmd;
        do @(posedge i_clk); while (!in_if.ready);
        predict_frame(kind, ch, pwr, cmd);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_power(input logic [CH_W-1:0] ch, input logic signed [POWER_W-1:0] pwr);
        send_item(KIND_POWER, ch, pwr, CMD_W'($urandom));
    endtask

    task automatic send_command(input logic [CH_W-1:0] ch, input logic [CMD_W-1:0] cmd);
        send_item(KIND_CMD, ch, POWER_W'($urandom), cmd);
    endtask

    task automatic stop_sending();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_results();
        while (pending_symbols.size() != 0) @(negedge i_clk);
    endtask

    // Block must be idle before registers change; dropped items leave no trace in the queue
    task automatic write_regs(input logic [TICK_W-1:0] zh, input logic [TICK_W-1:0] zl,
                              input logic [TICK_W-1:0] oh, input logic [TICK_W-1:0] ol,
                              input logic [MINP_W-1:0] minp);
        logic [CFG_IDX_W-1:0]  regs [5];
        logic [CFG_DATA_W-1:0] vals [5];
        regs = '{REG_ZERO_HIGH, REG_ZERO_LOW, REG_ONE_HIGH, REG_ONE_LOW, REG_MIN_POWER};
        vals = '{CFG_DATA_W'(zh), CFG_DATA_W'(zl), CFG_DATA_W'(oh), CFG_DATA_W'(ol),
                 CFG_DATA_W'(minp)};
        stop_sending();
        wait_results();
        repeat (12) @(negedge i_clk);
        for (int i = 0; i < 5; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= regs[i];
            cfg_if.data  <= vals[i];
            do @(posedge i_clk); while (!cfg_if.ready);
            case (regs[i])
                REG_ZERO_HIGH: zero_hi_ticks = vals[i][TICK_W-1:0];
                REG_ZERO_LOW:  zero_lo_ticks = vals[i][TICK_W-1:0];
                REG_ONE_HIGH:  one_hi_ticks  = vals[i][TICK_W-1:0];
                REG_ONE_LOW:   one_lo_ticks  = vals[i][TICK_W-1:0];
                REG_MIN_POWER: min_power_q   = vals[i][MINP_W-1:0];
                default: ;
            endcase
            cfg_writes++;
            @(negedge i_clk);
        end
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic signed [POWER_W-1:0] pick_power();
        int m;
        int v;
        m = int'(min_power_q);
        case ($urandom_range(3))
            0:       v = $urandom_range(65535) - 32768;
            1:       v = $urandom_range(m * 2 + 8);
            2:       v = 32768 - $urandom_range(400);
            default: v = $urandom_range(32767);
        endcase
        if ($urandom_range(1)) v = -v;
        if (v > 32767) v = 32767;
        return v[POWER_W-1:0];
    endfunction

    task automatic send_random_item();
        logic [CH_W-1:0]  ch;
        logic [CMD_W-1:0] cmd;
        ch  = ($urandom_range(99) < 8) ? CH_W'($urandom_range(7, CHANNELS))
                                       : CH_W'($urandom_range(CHANNELS - 1));
        cmd = ($urandom_range(99) < 15) ? CMD_W'($urandom) : CMD_W'($urandom_range(CMD_MAX));
        if ($urandom_range(99) < 30)
            send_command(ch, cmd);
        else
            send_power(ch, pick_power());
    endtask

    task automatic test_reset_directed();
        send_power(0, 16'sd32767);
        send_power(1, -16'sd32768);
        send_power(2, 16'sd0);
        send_power(3, 16'sd1);
        send_power(0, -16'sd1);      // stored positive, so small magnitude goes positive
        send_power(1, -16'sd100);    // stored negative, so the minimum stays negative
        send_power(2, 16'sd655);
        send_power(3, -16'sd655);
        send_power(0, 16'sd654);
        send_power(1, 16'sd32440);
        send_power(2, -16'sd32440);
        send_power(3, 16'sd661);     // reports zero: just inside 1.01x minimum
        send_power(3, 16'sd662);
        send_power(0, 16'sd16384);
        send_command(0, 8'd0);
        send_command(1, 8'd1);
        send_command(2, CMD_MAX);
        send_command(3, CMD_MAX + 8'd1);
        send_command(1, 8'd255);
        send_power(4, 16'sd1000);
        send_command(7, 8'd5);
        send_power(5, -16'sd20000);
        send_power(CHANNELS - 1, -16'sd32767);
        send_command(2, 8'd30);
    endtask

    task automatic test_zero_min_power();
        write_regs(8'd0, 8'd255, 8'd255, 8'd0, 14'd0);
        send_power(0, 16'sd0);
        send_power(1, -16'sd1);
        send_power(1, 16'sd0);
        send_power(2, 16'sd1);
        send_power(3, -16'sd32768);
        send_command(0, 8'd0);
        send_command(3, 8'd17);
    endtask

    task automatic test_max_min_power();
        write_regs(8'd255, 8'd0, 8'd0, 8'd255, 14'd16383);
        send_power(0, 16'sd100);
        send_power(1, -16'sd200);
        send_power(1, 16'sd5);
        send_power(2, 16'sd16383);
        send_power(3, -16'sd16384);
        send_power(0, 16'sd32767);
        send_command(2, 8'd42);
    endtask

    task automatic test_drain_pause();
        repeat (4) send_random_item();
        stop_sending();
        wait_results();
        repeat (4) send_random_item();
    endtask

    task automatic test_random(input int n, input int s_pct, input int r_pct);
        write_regs(TICK_W'($urandom), TICK_W'($urandom), TICK_W'($urandom), TICK_W'($urandom),
                   MINP_W'($urandom_range(3000)));
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n) send_random_item();
    endtask

    initial begin
        in_if.valid        = 1'b0;
        in_if.kind         = KIND_POWER;
        in_if.channel      = '0;
        in_if.power        = '0;
        in_if.command_code = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_ZERO_HIGH;
        cfg_if.data        = '0;
        out_if.ready       = 1'b0;
        i_rst_n            = 1'b0;
        send_idle_pct      = 27;
        recv_idle_pct      = 84;
        mismatches         = 0;
        symbols_checked    = 0;
        items_sent         = 0;
        cfg_writes         = 0;
        zero_hi_ticks      = 8'd40;
        zero_lo_ticks      = 8'd66;
        one_hi_ticks       = 8'd80;
        one_lo_ticks       = 8'd26;
        min_power_q        = 14'd655;
        for (int i = 0; i < CHANNELS; i++) chan_power[i] = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_directed();
        test_zero_min_power();
        test_max_min_power();
        test_drain_pause();
        test_random(95, 27, 84);
        test_random(95, 84, 27);
        test_random(95, 0, 0);

        stop_sending();
        wait_results();
        repeat (20) @(negedge i_clk);
        if (pending_symbols.size() != 0) mismatches++;
        $display("Sent %0d items (power, commands, dropped channels/commands), %0d reg writes",
                 items_sent, cfg_writes);
        $display("Checked %0d bit symbols across min-power and tick extremes, %0d mismatches",
                 symbols_checked, mismatches);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
